FILE: rtl/baro_temp_press_compensation_assert.svh
// Assertion macros for the barometer compensation block
`ifndef BARO_TEMP_PRESS_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESS_COMPENSATION_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define BTPC_ASSERT_IMP(lbl, clk, rstn, a, c) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
// Implication whose consequent is checked in the next cycle
`define BTPC_ASSERT_NXT(lbl, clk, rstn, a, c) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`endif

FILE: rtl/btpc_pkg.sv
package btpc_pkg;
	localparam int NSTG = 40;
	localparam logic [2:0] REG_CALIB_T = 3'd0;
	localparam logic [2:0] REG_CALIB_PA = 3'd1;
	localparam logic [2:0] REG_CALIB_PB = 3'd2;
	localparam logic [2:0] REG_P9 = 3'd3;
	localparam logic [2:0] REG_TLO = 3'd4;
	localparam logic [2:0] REG_THI = 3'd5;
	localparam logic [2:0] REG_PLO = 3'd6;
	localparam logic [2:0] REG_PHI = 3'd7;
	localparam logic [31:0] K64000 = 32'd64000;
	localparam logic [31:0] K1M = 32'd1048576;
	localparam logic [31:0] K3125 = 32'd3125;
	localparam logic [31:0] K32768 = 32'd32768;
	localparam logic [31:0] K128 = 32'd128;

	typedef struct packed {
		logic [47:0] ct;
		logic [63:0] pa;
		logic [63:0] pb;
		logic [15:0] p9;
		logic [15:0] tlo;
		logic [15:0] thi;
		logic [19:0] plo;
		logic [19:0] phi;
	} cfg_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] x, input int n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] r;
		r = a * b;
		return r[31:0];
	endfunction
endpackage

FILE: rtl/btpc_div.sv
// Pipelined restoring divider, one quotient bit per stage
module btpc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic [31:0] quo
);
	logic [31:0] n_s [0:32];
	logic [31:0] d_s [0:32];
	logic [31:0] r_s [0:32];

	assign n_s[0] = num;
	assign d_s[0] = den;
	assign r_s[0] = '0;

	// Produce one quotient bit per register stage
	for (genvar i = 0; i < 32; i++) begin : g_stg
		logic [32:0] tr;
		logic [32:0] df;
		logic [31:0] n_q, d_q, r_q;
		assign tr = {r_s[i], n_s[i][31]};
		assign df = tr - {1'b0, d_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				d_q <= d_s[i];
				if (!df[32]) begin
					r_q <= df[31:0];
					n_q <= {n_s[i][30:0], 1'b1};
				end else begin
					r_q <= tr[31:0];
					n_q <= {n_s[i][30:0], 1'b0};
				end
			end
		end
		assign n_s[i+1] = n_q;
		assign d_s[i+1] = d_q;
		assign r_s[i+1] = r_q;
	end
	assign quo = n_s[32];

	logic unused;
	assign unused = arst_n ^ (|r_s[32]) ^ (|d_s[32]);
endmodule

FILE: rtl/btpc_front.sv
// Temperature and pressure front end: 5 stages up to divider operands
module btpc_front (
	input  logic           clk,
	input  logic           en,
	input  btpc_pkg::cfg_t cfg,
	input  logic [19:0]    praw,
	input  logic [19:0]    traw,
	output logic [31:0]    t_o,
	output logic [31:0]    num_o,
	output logic [31:0]    den_o,
	output logic           big_o
);
	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
	assign t1 = {16'd0, cfg.ct[15:0]};
	assign t2 = btpc_pkg::sx16(cfg.ct[31:16]);
	assign t3 = btpc_pkg::sx16(cfg.ct[47:32]);
	assign p1 = {16'd0, cfg.pa[15:0]};
	assign p2 = btpc_pkg::sx16(cfg.pa[31:16]);
	assign p3 = btpc_pkg::sx16(cfg.pa[47:32]);
	assign p4 = btpc_pkg::sx16(cfg.pa[63:48]);
	assign p5 = btpc_pkg::sx16(cfg.pb[15:0]);
	assign p6 = btpc_pkg::sx16(cfg.pb[31:16]);

	// stage 1: temperature products
	logic [31:0] av1_s1, bb_s1, pr_s1;
	logic [31:0] a_c, b_c;
	assign a_c = {15'd0, traw[19:3]} - (t1 << 1);
	assign b_c = {16'd0, traw[19:4]} - t1;
	always_ff @(posedge clk) begin
		if (en) begin
			av1_s1 <= btpc_pkg::mul(a_c, t2);
			bb_s1 <= btpc_pkg::mul(b_c, b_c);
			pr_s1 <= {12'd0, praw};
		end
	end

	// stage 2: second temperature product
	logic [31:0] v1_s2, bt_s2, pr_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			v1_s2 <= btpc_pkg::asr(av1_s1, 11);
			bt_s2 <= btpc_pkg::mul(btpc_pkg::asr(bb_s1, 12), t3);
			pr_s2 <= pr_s1;
		end
	end

	// stage 3: fine temperature, pressure v1 and square
	logic [31:0] tf_c, pv1_c, q_c;
	assign tf_c = v1_s2 + btpc_pkg::asr(bt_s2, 14);
	assign pv1_c = btpc_pkg::asr(tf_c, 1) - btpc_pkg::K64000;
	assign q_c = btpc_pkg::asr(pv1_c, 2);
	logic [31:0] tf_s3, v1_s3, qq_s3, pr_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			tf_s3 <= tf_c;
			v1_s3 <= pv1_c;
			qq_s3 <= btpc_pkg::mul(q_c, q_c);
			pr_s3 <= pr_s2;
		end
	end

	// stage 4: coefficient products
	logic [31:0] tt_s4, a6_s4, a5_s4, a3_s4, a2_s4, pr_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			tt_s4 <= btpc_pkg::mul(tf_s3, 32'd5) + btpc_pkg::K128;
			a6_s4 <= btpc_pkg::mul(btpc_pkg::asr(qq_s3, 11), p6);
			a5_s4 <= btpc_pkg::mul(v1_s3, p5);
			a3_s4 <= btpc_pkg::mul(p3, btpc_pkg::asr(qq_s3, 13));
			a2_s4 <= btpc_pkg::mul(p2, v1_s3);
			pr_s4 <= pr_s3;
		end
	end

	// stage 5: divisor product and dividend
	logic [31:0] v2_c, w_c, x_c;
	assign v2_c = btpc_pkg::asr(a6_s4 + (a5_s4 << 1), 2) + (p4 << 16);
	assign w_c = btpc_pkg::asr(btpc_pkg::asr(a3_s4, 3) + btpc_pkg::asr(a2_s4, 1), 18);
	assign x_c = (btpc_pkg::K1M - pr_s4) - btpc_pkg::asr(v2_c, 12);
	logic [31:0] t_s5, d_s5, n_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			t_s5 <= btpc_pkg::asr(tt_s4, 8);
			d_s5 <= btpc_pkg::mul(btpc_pkg::K32768 + w_c, p1);
			n_s5 <= btpc_pkg::mul(x_c, btpc_pkg::K3125);
		end
	end

	// operands for the divider
	assign den_o = btpc_pkg::asr(d_s5, 15);
	assign big_o = n_s5[31];
	assign num_o = n_s5[31] ? n_s5 : {n_s5[30:0], 1'b0};
	assign t_o = t_s5;
endmodule

FILE: rtl/btpc_back.sv
// Pressure correction terms and output clamps: 3 stages
module btpc_back (
	input  logic           clk,
	input  logic           en,
	input  btpc_pkg::cfg_t cfg,
	input  logic [31:0]    t_i,
	input  logic [31:0]    q_i,
	input  logic           big_i,
	input  logic           zero_i,
	output logic [15:0]    temp_o,
	output logic           talm_o,
	output logic [19:0]    pres_o,
	output logic           palm_o
);
	logic [31:0] p_c;
	assign p_c = zero_i ? '0 : (big_i ? {q_i[30:0], 1'b0} : q_i);

	// stage 1: square term and p8 product
	logic [31:0] p_s1, m_s1, v2_s1, t_s1;
	logic z_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= p_c;
			m_s1 <= btpc_pkg::mul(p_c >> 3, p_c >> 3) >> 13;
			v2_s1 <= btpc_pkg::mul(p_c >> 2, btpc_pkg::sx16(cfg.pb[63:48]));
			t_s1 <= t_i;
			z_s1 <= zero_i;
		end
	end

	// stage 2: p9 product
	logic [31:0] p_s2, v1_s2, v2_s2, t_s2;
	logic z_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= p_s1;
			v1_s2 <= btpc_pkg::mul(btpc_pkg::sx16(cfg.p9), m_s1);
			v2_s2 <= btpc_pkg::asr(v2_s1, 13);
			t_s2 <= t_s1;
			z_s2 <= z_s1;
		end
	end

	// stage 3: final sum and clamps
	logic [31:0] pf_c, lo, hi, plo, phi;
	assign pf_c = z_s2 ? '0 : p_s2 + btpc_pkg::asr(btpc_pkg::asr(v1_s2, 12) + v2_s2
		+ btpc_pkg::sx16(cfg.pb[47:32]), 4);
	assign lo = btpc_pkg::sx16(cfg.tlo);
	assign hi = btpc_pkg::sx16(cfg.thi);
	assign plo = {12'd0, cfg.plo};
	assign phi = {12'd0, cfg.phi};
	always_ff @(posedge clk) begin
		if (en) begin
			if ($signed(t_s2) < $signed(lo)) begin
				temp_o <= lo[15:0];
				talm_o <= 1'b1;
			end else if ($signed(t_s2) > $signed(hi)) begin
				temp_o <= hi[15:0];
				talm_o <= 1'b1;
			end else begin
				temp_o <= t_s2[15:0];
				talm_o <= 1'b0;
			end
			if (pf_c < plo) begin
				pres_o <= cfg.plo;
				palm_o <= 1'b1;
			end else if (pf_c > phi) begin
				pres_o <= cfg.phi;
				palm_o <= 1'b1;
			end else begin
				pres_o <= pf_c[19:0];
				palm_o <= 1'b0;
			end
		end
	end
endmodule

FILE: rtl/baro_temp_press_compensation.sv
// Channel   | dir | signals
// s_axis    | in  | s_axis_tvalid/tready/tdata[47:0]
// m_axis    | out | m_axis_tvalid/tready/tdata[39:0]
// cfg       | in  | cfg_valid/cfg_ready/cfg_index[2:0]/cfg_data[63:0]
// One item per cycle while the output is not stalled; 5 front, 32 divider, 3 back stages.
// The 32-stage divider sets the latency. The whole pipe advances whenever
// the output register is empty or taken, so a stall holds every stage.
// Reset clears valid bits and calibration coefficients and loads the limit defaults.
module baro_temp_press_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb, temp_xlsb
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// temperature[15:0], pressure[35:16], temp_alarm[36], press_alarm[37], zero
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	`include "baro_temp_press_compensation_assert.svh"

	btpc_pkg::cfg_t cfg_q;
	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{ct: '0, pa: '0, pb: '0, p9: '0,
				tlo: 16'hF060, thi: 16'd8500, plo: 20'd30000, phi: 20'd110000};
		end else if (cfg_valid) begin
			case (cfg_index)
				btpc_pkg::REG_CALIB_T:  cfg_q.ct <= cfg_data[47:0];
				btpc_pkg::REG_CALIB_PA: cfg_q.pa <= cfg_data;
				btpc_pkg::REG_CALIB_PB: cfg_q.pb <= cfg_data;
				btpc_pkg::REG_P9:       cfg_q.p9 <= cfg_data[15:0];
				btpc_pkg::REG_TLO:      cfg_q.tlo <= cfg_data[15:0];
				btpc_pkg::REG_THI:      cfg_q.thi <= cfg_data[15:0];
				btpc_pkg::REG_PLO:      cfg_q.plo <= cfg_data[19:0];
				btpc_pkg::REG_PHI:      cfg_q.phi <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Advance valid bits with the pipe
	logic [btpc_pkg::NSTG-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[btpc_pkg::NSTG-2:0], s_axis_tvalid};
	end
	assign m_axis_tvalid = vld_q[btpc_pkg::NSTG-1];

	logic [19:0] praw, traw;
	assign praw = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:20]};
	assign traw = {s_axis_tdata[31:24], s_axis_tdata[39:32], s_axis_tdata[47:44]};

	logic [31:0] t5, num, den, quo;
	logic big;
	btpc_front u_front (.clk, .en, .cfg(cfg_q), .praw, .traw,
		.t_o(t5), .num_o(num), .den_o(den), .big_o(big));

	btpc_div u_div (.clk, .arst_n, .en, .num, .den, .quo);

	// Carry side data alongside the divider
	logic [31:0] t_d [0:32];
	logic big_d [0:32];
	logic zero_d [0:32];
	assign t_d[0] = t5;
	assign big_d[0] = big;
	assign zero_d[0] = (den == '0);
	for (genvar i = 0; i < 32; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				t_d[i+1] <= t_d[i];
				big_d[i+1] <= big_d[i];
				zero_d[i+1] <= zero_d[i];
			end
		end
	end

	logic [15:0] temp;
	logic [19:0] pres;
	logic talm, palm;
	btpc_back u_back (.clk, .en, .cfg(cfg_q), .t_i(t_d[32]), .q_i(quo),
		.big_i(big_d[32]), .zero_i(zero_d[32]),
		.temp_o(temp), .talm_o(talm), .pres_o(pres), .palm_o(palm));

	assign m_axis_tdata = {2'b00, palm, talm, pres, temp};

	`BTPC_ASSERT_IMP(a_stall_ready, clk, arst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
	`BTPC_ASSERT_NXT(a_hold_out, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`BTPC_ASSERT_IMP(a_cfg_rdy, clk, arst_n, cfg_valid, cfg_ready)
endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
	typedef struct packed {
		logic       palarm;
		logic       talarm;
		logic [19:0] press;
		logic [15:0] temp;
	} reading_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	baro_temp_press_compensation DUT (.*);

	always #2 clk = ~clk;

	// model copy of the registers
	logic [47:0] m_ct;
	logic [63:0] m_pa, m_pb;
	logic [15:0] m_p9, m_tlo, m_thi;
	logic [19:0] m_plo, m_phi;

	logic [47:0] raw_q[$];
	reading_t    reading_q[$];
	int          errors = 0;
	int          send_idle = 0, recv_stall = 0, hold_off = 0;
	int          quiet = 0;
	logic        cfg_done = 1'b0;

	function automatic logic [31:0] shr(logic [31:0] x, int n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [31:0] ext(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// compensate one raw readout with the current coefficients
	function automatic reading_t compensate(logic [47:0] d);
		logic [31:0] praw, traw, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] a, b, v1, v2, tf, q, qq, p, m, t, lo, hi;
		reading_t r;
		praw = {12'd0, d[7:0], 12'd0} | {d[15:8], 4'd0} | d[23:20];
		traw = {12'd0, d[31:24], 12'd0} | {d[39:32], 4'd0} | d[47:44];
		t1 = {16'd0, m_ct[15:0]}; t2 = ext(m_ct[31:16]); t3 = ext(m_ct[47:32]);
		p1 = {16'd0, m_pa[15:0]}; p2 = ext(m_pa[31:16]);
		p3 = ext(m_pa[47:32]); p4 = ext(m_pa[63:48]);
		p5 = ext(m_pb[15:0]); p6 = ext(m_pb[31:16]);
		p7 = ext(m_pb[47:32]); p8 = ext(m_pb[63:48]); p9 = ext(m_p9);
		a = shr(traw, 3) - (t1 << 1);
		v1 = shr(a * t2, 11);
		b = shr(traw, 4) - t1;
		v2 = shr(shr(b * b, 12) * t3, 14);
		tf = v1 + v2;
		t = shr(tf * 32'd5 + 32'd128, 8);
		lo = ext(m_tlo); hi = ext(m_thi);
		r.talarm = ($signed(t) < $signed(lo)) || ($signed(t) > $signed(hi));
		if (r.talarm) t = ($signed(t) < $signed(lo)) ? lo : hi;
		r.temp = t[15:0];
		v1 = shr(tf, 1) - 32'd64000;
		q = shr(v1, 2);
		qq = q * q;
		v2 = shr(qq, 11) * p6;
		v2 = v2 + ((v1 * p5) << 1);
		v2 = shr(v2, 2) + (p4 << 16);
		v1 = shr(shr(p3 * shr(qq, 13), 3) + shr(p2 * v1, 1), 18);
		v1 = shr((32'd32768 + v1) * p1, 15);
		p = ((32'd1048576 - praw) - shr(v2, 12)) * 32'd3125;
		if (v1 != 0) begin
			if (p < 32'h80000000) p = (p << 1) / v1;
			else p = (p / v1) * 32'd2;
			m = ((p >> 3) * (p >> 3)) >> 13;
			v1 = shr(p9 * m, 12);
			v2 = shr((p >> 2) * p8, 13);
			p = p + shr(v1 + v2 + p7, 4);
		end else begin
			p = 0;
		end
		r.palarm = (p < {12'd0, m_plo}) || (p > {12'd0, m_phi});
		if (r.palarm) p = (p < {12'd0, m_plo}) ? {12'd0, m_plo} : {12'd0, m_phi};
		r.press = p[19:0];
		return r;
	endfunction

	task automatic report(string what, logic [39:0] got, logic [39:0] want);
		$display("error: %s got %h expected %h", what, got, want);
		errors++;
	endtask

	// drive readouts from the pending queue, predicting each one accepted
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			reading_q.push_back(compensate(s_axis_tdata));
			void'(raw_q.pop_front());
		end
		if ((!s_axis_tvalid || s_axis_tready) && raw_q.size() != 0) begin
			if ($urandom_range(99) < send_idle) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= raw_q[0];
			end
		end else if (s_axis_tready) begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// check results and stall the receiver
	always @(posedge clk) begin
		reading_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (reading_q.size() == 0) begin
				report("unexpected result", m_axis_tdata, '0);
			end else begin
				want = reading_q.pop_front();
				if (m_axis_tdata[15:0] !== want.temp)
					report("temperature", m_axis_tdata, {2'b0, want});
				if (m_axis_tdata[35:16] !== want.press)
					report("pressure", m_axis_tdata, {2'b0, want});
				if (m_axis_tdata[36] !== want.talarm)
					report("temp_alarm", m_axis_tdata, {2'b0, want});
				if (m_axis_tdata[37] !== want.palarm)
					report("press_alarm", m_axis_tdata, {2'b0, want});
			end
		end
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n && ($urandom_range(99) >= recv_stall);
		end
	end

	// watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready) || hold_off > 0)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			btpc_pkg::REG_CALIB_T:  m_ct = val[47:0];
			btpc_pkg::REG_CALIB_PA: m_pa = val;
			btpc_pkg::REG_CALIB_PB: m_pb = val;
			btpc_pkg::REG_P9:       m_p9 = val[15:0];
			btpc_pkg::REG_TLO:      m_tlo = val[15:0];
			btpc_pkg::REG_THI:      m_thi = val[15:0];
			btpc_pkg::REG_PLO:      m_plo = val[19:0];
			btpc_pkg::REG_PHI:      m_phi = val[19:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		while (raw_q.size() != 0 || s_axis_tvalid || reading_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic logic [47:0] typical_raw();
		logic [19:0] pr, tr;
		pr = 20'd415148 + $urandom_range(40000) - 20000;
		tr = 20'd519888 + $urandom_range(60000) - 30000;
		return {tr[3:0], 4'($urandom), tr[11:4], tr[19:12],
			pr[3:0], 4'($urandom), pr[11:4], pr[19:12]};
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// typical coefficients of a real part
	task automatic load_typical();
		write_reg(btpc_pkg::REG_CALIB_T, {-16'sd1000, 16'sd26435, 16'd27504});
		write_reg(btpc_pkg::REG_CALIB_PA, {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477});
		write_reg(btpc_pkg::REG_CALIB_PB, {-16'sd12000, 16'sd15500, -16'sd7, 16'sd140});
		write_reg(btpc_pkg::REG_P9, 64'd6000);
	endtask

	initial begin
		int ph;
		m_ct = 0; m_pa = 0; m_pb = 0; m_p9 = 0;
		m_tlo = 16'hF060; m_thi = 16'd8500; m_plo = 20'd30000; m_phi = 20'd110000;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// zero divisor with reset coefficients
		raw_q.push_back('0);
		raw_q.push_back('1);
		drain();
		load_typical();
		// directed extremes
		raw_q.push_back('0);
		raw_q.push_back('1);
		raw_q.push_back(48'h0F00FF_0F00FF);
		raw_q.push_back(48'hF0FFFF_F0FFFF);
		raw_q.push_back(48'h00_80_80_00_80_80);
		for (int i = 0; i < 8; i++) raw_q.push_back(typical_raw());
		drain();
		// crossed and tight limits
		write_reg(btpc_pkg::REG_TLO, 64'd3000);
		write_reg(btpc_pkg::REG_THI, 64'd1000);
		write_reg(btpc_pkg::REG_PLO, 64'd100000);
		write_reg(btpc_pkg::REG_PHI, 64'd90000);
		for (int i = 0; i < 8; i++) raw_q.push_back(typical_raw());
		drain();
		write_reg(btpc_pkg::REG_TLO, 64'h8000);
		write_reg(btpc_pkg::REG_THI, 64'h7FFF);
		write_reg(btpc_pkg::REG_PLO, 64'd0);
		write_reg(btpc_pkg::REG_PHI, 64'hFFFFF);
		raw_q.push_back(typical_raw());
		raw_q.push_back('1);
		drain();
		// random phases with idling profiles
		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 64; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 64; end
				3: begin send_idle = 35; recv_stall = 35; end
			endcase
			if (ph == 2 || ph == 6) begin
				write_reg(btpc_pkg::REG_CALIB_T, rnd64());
				write_reg(btpc_pkg::REG_CALIB_PA, rnd64());
				write_reg(btpc_pkg::REG_CALIB_PB, rnd64());
				write_reg(btpc_pkg::REG_P9, rnd64());
				write_reg(btpc_pkg::REG_TLO, rnd64());
				write_reg(btpc_pkg::REG_THI, rnd64());
				write_reg(btpc_pkg::REG_PLO, rnd64());
				write_reg(btpc_pkg::REG_PHI, rnd64());
			end else begin
				load_typical();
				write_reg(btpc_pkg::REG_TLO, 64'hF060 - $urandom_range(3000));
				write_reg(btpc_pkg::REG_THI, 64'd4000 + $urandom_range(6000));
				write_reg(btpc_pkg::REG_PLO, 64'd30000 + $urandom_range(60000));
				write_reg(btpc_pkg::REG_PHI, 64'd95000 + $urandom_range(30000));
			end
			if (ph == 0) hold_off = 300;
			for (int i = 0; i < 210; i++)
				raw_q.push_back(($urandom_range(9) < 7) ? typical_raw() : 48'(rnd64()));
			drain();
		end
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
